FILE: rtl/core/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants for the breakpoint-table airspeed schedule:
// table entry layout, interpolator payloads, register and function codes.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 5;

  // Fixed-point scaling
  localparam int FULL_SCALE  = 16384;
  localparam int HALF_SCALE  = FULL_SCALE / 2;
  localparam int QUART_SCALE = FULL_SCALE / 4;
  localparam int DM_GAIN     = (FULL_SCALE / 10) * 4;

  // Field widths
  localparam int SPEED_W   = 15;
  localparam int DATA_W    = 16;
  localparam int X_W       = 17;
  localparam int DY_W      = 17;
  localparam int OFF_W     = 18;
  localparam int GAIN_W    = 6;
  localparam int DIVS_W    = 15;
  localparam int NUM_W     = 29;
  localparam int DIV_STEPS = 16;
  localparam int PROD_W    = 34;
  localparam int SH_W      = 52;
  localparam int DM_W      = 13;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Airspeed mode codes (anything else behaves as fixed cruise)
  localparam logic [1:0] MODE_CAMBER       = 2'd0;
  localparam logic [1:0] MODE_CAMBER_PITCH = 2'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_COUNT   = 2'd1,
    CFG_DEFAULT = 2'd2
  } cfg_idx_t;

  // One stored breakpoint
  typedef struct packed {
    logic signed [DATA_W-1:0] cond;
    logic [SPEED_W-1:0]       cruise;
    logic [SPEED_W-1:0]       stall;
    logic [SPEED_W-1:0]       vne;
  } entry_t;

  // Side data riding along with an evaluate item
  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] pitch;
  } tag_t;

  // Interpolator operands
  typedef struct packed {
    logic signed [X_W-1:0]    x;
    logic signed [X_W-1:0]    x1;
    logic signed [X_W-1:0]    x2;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] y2;
    tag_t                     tag;
  } lerp_in_t;

  // Interpolator context carried past the divider
  typedef struct packed {
    logic                     flat;
    logic                     neg;
    logic signed [DATA_W-1:0] y1;
    logic signed [OFF_W-1:0]  off;
    logic signed [GAIN_W-1:0] gain;
    tag_t                     tag;
  } lerp_ctx_t;

endpackage

FILE: rtl/core/bts_ram.sv
// ----------------------------------------------------------------------------
// bts_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then read-before-write on both ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/core/bts_div.sv
// ----------------------------------------------------------------------------
// bts_div
// Pipelined restoring divider: 29-bit magnitude by 15-bit divisor, one
// quotient bit per stage, 16 stages. Context travels alongside.
// ----------------------------------------------------------------------------
module bts_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [bts_pkg::NUM_W-1:0]  num_mag,
  input  logic [bts_pkg::DIVS_W-1:0] divisor,
  input  bts_pkg::lerp_ctx_t         in_ctx,
  output logic                       out_valid,
  output logic [bts_pkg::DATA_W-1:0] out_q,
  output bts_pkg::lerp_ctx_t         out_ctx
);
  import bts_pkg::*;

  // Stage registers
  logic [DIV_STEPS-1:0] vld;
  logic [DIVS_W-1:0]    rem [DIV_STEPS];
  logic [DATA_W-1:0]    lo  [DIV_STEPS];
  logic [DATA_W-1:0]    quo [DIV_STEPS];
  logic [DIVS_W-1:0]    dvs [DIV_STEPS];
  lerp_ctx_t            ctx [DIV_STEPS];

  // Step inputs and results
  logic [DIVS_W-1:0] rem_in [DIV_STEPS];
  logic [DATA_W-1:0] lo_in  [DIV_STEPS];
  logic [DATA_W-1:0] quo_in [DIV_STEPS];
  logic [DIVS_W-1:0] dvs_in [DIV_STEPS];
  lerp_ctx_t         ctx_in [DIV_STEPS];
  logic [DIVS_W-1:0] rem_next [DIV_STEPS];
  logic [DATA_W-1:0] quo_next [DIV_STEPS];

  // Feed each step from the previous stage
  always_comb begin
    rem_in[0] = DIVS_W'(num_mag[NUM_W-1:DIV_STEPS]);
    lo_in[0]  = num_mag[DIV_STEPS-1:0];
    quo_in[0] = '0;
    dvs_in[0] = divisor;
    ctx_in[0] = in_ctx;
    for (int j = 1; j < DIV_STEPS; j++) begin
      rem_in[j] = rem[j-1];
      lo_in[j]  = lo[j-1];
      quo_in[j] = quo[j-1];
      dvs_in[j] = dvs[j-1];
      ctx_in[j] = ctx[j-1];
    end
  end

  // Trial subtract per step
  always_comb begin
    logic [DIVS_W:0] trial;
    for (int j = 0; j < DIV_STEPS; j++) begin
      trial = {rem_in[j], lo_in[j][DATA_W-1]};
      if (trial >= {1'b0, dvs_in[j]}) begin
        rem_next[j] = DIVS_W'(trial - {1'b0, dvs_in[j]});
        quo_next[j] = {quo_in[j][DATA_W-2:0], 1'b1};
      end else begin
        rem_next[j] = trial[DIVS_W-1:0];
        quo_next[j] = {quo_in[j][DATA_W-2:0], 1'b0};
      end
    end
  end

  // Valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
  end

  // Payload line
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem[j] <= rem_next[j];
        lo[j]  <= {lo_in[j][DATA_W-2:0], 1'b0};
        quo[j] <= quo_next[j];
        dvs[j] <= dvs_in[j];
        ctx[j] <= ctx_in[j];
      end
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign out_q     = quo[DIV_STEPS-1];
  assign out_ctx   = ctx[DIV_STEPS-1];

endmodule

FILE: rtl/core/bts_lerp.sv
// ----------------------------------------------------------------------------
// bts_lerp
// Normalised fixed-point linear interpolator, 20 stages: normalise, divide
// (16), multiply, gain shift, offset add with saturation.
// ----------------------------------------------------------------------------
module bts_lerp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  bts_pkg::lerp_in_t                 lin,
  output logic                              out_valid,
  output logic signed [bts_pkg::DATA_W-1:0] out_y,
  output bts_pkg::tag_t                     out_tag
);
  import bts_pkg::*;

  // Normalisation (combinational)
  logic signed [OFF_W-1:0] span;
  logic signed [OFF_W-1:0] off;
  logic signed [DY_W-1:0]  dy;
  logic                    flat;
  logic [DIVS_W-1:0]       span_n;
  logic signed [GAIN_W-1:0] gain_sp;
  logic [2:0]              k;
  logic [NUM_W-1:0]        num_mag;

  always_comb begin
    logic [4:0]          msb;
    logic [4:0]          sh_r;
    logic [DY_W-1:0]     span_mag;
    logic [DY_W-1:0]     dmag;
    logic signed [DY_W-1:0] dsh;
    logic                fits;
    span     = OFF_W'(lin.x2) - OFF_W'(lin.x1);
    off      = OFF_W'(lin.x) - OFF_W'(lin.x1);
    dy       = DY_W'(lin.y2) - DY_W'(lin.y1);
    flat     = (span <= 0) || (lin.y1 == lin.y2);
    span_mag = span[DY_W-1:0];
    // leading one of the span
    msb = '0;
    for (int i = 0; i < DY_W; i++) begin
      if (span_mag[i]) msb = 5'(i);
    end
    // bring the span into [half scale, full scale]
    sh_r = '0;
    priority if (span_mag > DY_W'(FULL_SCALE)) begin
      // halving stops as soon as the span reaches full scale exactly
      sh_r = msb - 5'd13;
      if ((span_mag >> (msb - 5'd14)) == DY_W'(FULL_SCALE)) sh_r = msb - 5'd14;
      span_n  = DIVS_W'(span_mag >> sh_r);
      gain_sp = GAIN_W'(0) - GAIN_W'(sh_r);
    end else if (span_mag < DY_W'(HALF_SCALE)) begin
      span_n  = DIVS_W'(span_mag << (5'd13 - msb));
      gain_sp = GAIN_W'(5'd13 - msb);
    end else begin
      span_n  = DIVS_W'(span_mag);
      gain_sp = '0;
    end
    // smallest numerator shift that keeps the quotient in range
    k = 3'd4;
    for (int i = 4; i >= 0; i--) begin
      dsh  = dy >>> i;
      fits = (dy > 0) ? (dsh <= DY_W'(QUART_SCALE)) : (dsh >= -DY_W'(QUART_SCALE));
      if (fits) k = 3'(i);
    end
    dmag    = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);
    num_mag = NUM_W'({dmag, 16'b0} >> k);
  end

  // Normalise stage register
  logic                    p_valid;
  logic [NUM_W-1:0]        p_num;
  logic [DIVS_W-1:0]       p_div;
  lerp_ctx_t               p_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num      <= num_mag;
      p_div      <= span_n;
      p_ctx.flat <= flat;
      p_ctx.neg  <= dy[DY_W-1];
      p_ctx.y1   <= lin.y1;
      p_ctx.off  <= off;
      p_ctx.gain <= gain_sp + GAIN_W'(k);
      p_ctx.tag  <= lin.tag;
    end
  end

  // Divider
  logic                d_valid;
  logic [DATA_W-1:0]   d_q;
  lerp_ctx_t           d_ctx;

  bts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p_valid),
    .num_mag  (p_num),
    .divisor  (p_div),
    .in_ctx   (p_ctx),
    .out_valid(d_valid),
    .out_q    (d_q),
    .out_ctx  (d_ctx)
  );

  // Saturate quotient, multiply by offset
  logic signed [DATA_W-1:0] q_sat;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    if (d_ctx.neg) begin
      q_sat = (d_q > 16'd32768) ? -16'sd32768 : DATA_W'(-$signed({1'b0, d_q}));
    end else begin
      q_sat = (d_q > 16'd32767) ? 16'sd32767 : $signed(d_q);
    end
    prod = q_sat * d_ctx.off;
  end

  logic                     m_valid;
  logic signed [PROD_W-1:0] m_prod;
  lerp_ctx_t                m_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod <= prod;
      m_ctx  <= d_ctx;
    end
  end

  // Gain shift: left for positive gain, floor right shift otherwise
  logic signed [SH_W-1:0] shifted;

  always_comb begin
    logic signed [SH_W-1:0] ext;
    ext = SH_W'(m_prod);
    if (m_ctx.gain >= 0) begin
      shifted = ext <<< m_ctx.gain[GAIN_W-2:0];
    end else begin
      shifted = ext >>> GAIN_W'(-m_ctx.gain);
    end
  end

  logic                   s_valid;
  logic signed [SH_W-1:0] s_sh;
  lerp_ctx_t              s_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_sh  <= shifted;
      s_ctx <= m_ctx;
    end
  end

  // Add y1 and saturate; a flat span passes y1 through unchanged
  logic signed [DATA_W-1:0] y_next;

  always_comb begin
    logic signed [SH_W-DATA_W:0] sum;
    sum = (SH_W-DATA_W+1)'(s_sh >>> 16) + (SH_W-DATA_W+1)'(s_ctx.y1);
    priority if (s_ctx.flat) begin
      y_next = s_ctx.y1;
    end else if (sum > 32767) begin
      y_next = 16'sd32767;
    end else if (sum < -32768) begin
      y_next = -16'sd32768;
    end else begin
      y_next = DATA_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_y   <= y_next;
      out_tag <= s_ctx.tag;
    end
  end

endmodule

FILE: rtl/core/breakpoint_table_airspeed_schedule_core.sv
// ----------------------------------------------------------------------------
// breakpoint_table_airspeed_schedule_core
// Camber breakpoint table with piecewise-linear airspeed interpolation and an
// optional second interpolation on pitch toward stall or never-exceed speed.
// ----------------------------------------------------------------------------
// Pipeline: 2 lookup stages, the first loaded at the accepting edge, two
//   20-stage interpolators in series, one output stage. Throughput: one beat
//   per cycle; the whole pipeline holds when the output register is full and
//   not taken.
// Reset: synchronous; clears valid bits and the configuration registers.
//   Table contents are undefined until loaded; load beats write at once.
module breakpoint_table_airspeed_schedule_core
  import bts_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [bts_pkg::IDX_W-1:0]         entry_index,
  input  logic signed [bts_pkg::DATA_W-1:0] entry_condition,
  input  logic [bts_pkg::SPEED_W-1:0]       entry_cruise,
  input  logic [bts_pkg::SPEED_W-1:0]       entry_stall,
  input  logic [bts_pkg::SPEED_W-1:0]       entry_vne,
  input  logic signed [bts_pkg::DATA_W-1:0] camber_input,
  input  logic signed [bts_pkg::DATA_W-1:0] pitch_input,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bts_pkg::DATA_W-1:0] airspeed_demand,
  output logic signed [bts_pkg::DM_W-1:0]   speed_demand_dm
);

  // Configuration registers
  logic [1:0]         airspeed_mode;
  logic [COUNT_W-1:0] point_count;
  logic [SPEED_W-1:0] default_cruise;

  always_ff @(posedge clk) begin
    if (rst) begin
      airspeed_mode  <= MODE_CAMBER;
      point_count    <= COUNT_W'(1);
      default_cruise <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    airspeed_mode  <= cfg_data[1:0];
        CFG_COUNT:   point_count    <= cfg_data[COUNT_W-1:0];
        CFG_DEFAULT: default_cruise <= cfg_data[SPEED_W-1:0];
        default:     ;
      endcase
    end
  end

  // Global advance: the output register is free or being taken
  logic en;
  logic load;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign load     = in_valid && in_ready && (func == FUNC_LOAD);

  // Breakpoint table: conditions in flops for the parallel compare,
  // full entries in RAM for the indexed reads
  logic signed [DATA_W-1:0] cond_q [TABLE_DEPTH];
  entry_t                   wr_entry;
  entry_t                   ent_a;
  entry_t                   ent_b;

  always_ff @(posedge clk) begin
    if (load) begin
      cond_q[entry_index] <= entry_condition;
    end
  end

  assign wr_entry = '{cond: entry_condition, cruise: entry_cruise,
                      stall: entry_stall, vne: entry_vne};

  // Lookup stage 1: capture the evaluate beat
  logic                     v1;
  logic signed [DATA_W-1:0] cam1;
  tag_t                     tag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && (func == FUNC_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cam1       <= camber_input;
      tag1.mode  <= airspeed_mode;
      tag1.pitch <= pitch_input;
    end
  end

  // Segment search: first pair whose interval holds the camber
  logic [COUNT_W-1:0] n_used;
  logic [IDX_W-1:0]   idx_a;
  logic [IDX_W-1:0]   idx_b;
  logic               byp;

  always_comb begin
    logic [TABLE_DEPTH-1:0]   ge;
    logic [TABLE_DEPTH-2:0]   hit;
    logic                     found;
    logic [IDX_W-1:0]         idx_hit;
    if (point_count == '0) begin
      n_used = COUNT_W'(1);
    end else if (point_count > COUNT_W'(TABLE_DEPTH)) begin
      n_used = COUNT_W'(TABLE_DEPTH);
    end else begin
      n_used = point_count;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ge[i] = cam1 >= cond_q[i];
    end
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      hit[i] = ge[i] && !ge[i+1] && (COUNT_W'(i + 1) < n_used);
    end
    found   = 1'b0;
    idx_hit = '0;
    for (int i = TABLE_DEPTH - 2; i >= 0; i--) begin
      if (hit[i]) begin
        found   = 1'b1;
        idx_hit = IDX_W'(i);
      end
    end
    priority if (!ge[0]) begin
      idx_a = '0;
      byp   = 1'b1;
    end else if (found) begin
      idx_a = idx_hit;
      byp   = 1'b0;
    end else begin
      idx_a = IDX_W'(n_used - COUNT_W'(1));
      byp   = 1'b1;
    end
    idx_b = idx_a + IDX_W'(1);
  end

  bts_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .we     (load),
    .waddr  (entry_index),
    .wdata  (wr_entry),
    .re     (en),
    .raddr_a(idx_a),
    .raddr_b(idx_b),
    .rdata_a(ent_a),
    .rdata_b(ent_b)
  );

  // Lookup stage 2: entries arrive from RAM
  logic                     v2;
  logic                     byp2;
  logic signed [DATA_W-1:0] cam2;
  tag_t                     tag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp2 <= byp;
      cam2 <= cam1;
      tag2 <= tag1;
    end
  end

  // Camber interpolation: cruise and pitch target in parallel
  lerp_in_t                 cru_in;
  lerp_in_t                 pnt_in;
  logic [SPEED_W-1:0]       pnt_lo;
  logic [SPEED_W-1:0]       pnt_hi;

  always_comb begin
    pnt_lo = tag2.pitch[DATA_W-1] ? ent_a.vne : ent_a.stall;
    pnt_hi = tag2.pitch[DATA_W-1] ? ent_b.vne : ent_b.stall;

    cru_in.x   = X_W'(cam2);
    cru_in.x1  = X_W'(ent_a.cond);
    cru_in.x2  = byp2 ? X_W'(ent_a.cond) : X_W'(ent_b.cond);
    cru_in.y1  = DATA_W'(ent_a.cruise);
    cru_in.y2  = DATA_W'(ent_b.cruise);
    cru_in.tag = tag2;

    pnt_in     = cru_in;
    pnt_in.y1  = DATA_W'(pnt_lo);
    pnt_in.y2  = DATA_W'(pnt_hi);
  end

  logic                     a_valid;
  logic signed [DATA_W-1:0] a_cruise;
  logic signed [DATA_W-1:0] a_point;
  tag_t                     a_tag;

  bts_lerp u_lerp_cruise (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .lin      (cru_in),
    .out_valid(a_valid),
    .out_y    (a_cruise),
    .out_tag  (a_tag)
  );

  bts_lerp u_lerp_point (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .lin      (pnt_in),
    .out_valid(),
    .out_y    (a_point),
    .out_tag  ()
  );

  // Pitch interpolation, or pass-through of cruise / default
  lerp_in_t b_in;

  always_comb begin
    b_in.x   = X_W'(a_tag.pitch);
    b_in.x1  = '0;
    b_in.x2  = '0;
    b_in.y1  = a_cruise;
    b_in.y2  = a_cruise;
    b_in.tag = a_tag;
    unique case (a_tag.mode)
      MODE_CAMBER: ;
      MODE_CAMBER_PITCH: begin
        if (a_tag.pitch[DATA_W-1]) begin
          b_in.x1 = -X_W'(FULL_SCALE);
          b_in.y1 = a_point;
        end else begin
          b_in.x2 = X_W'(FULL_SCALE);
          b_in.y2 = a_point;
        end
      end
      default: begin
        b_in.y1 = DATA_W'(default_cruise);
        b_in.y2 = DATA_W'(default_cruise);
      end
    endcase
  end

  logic                     b_valid;
  logic signed [DATA_W-1:0] b_y;

  bts_lerp u_lerp_pitch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_valid),
    .lin      (b_in),
    .out_valid(b_valid),
    .out_y    (b_y),
    .out_tag  ()
  );

  // Output register with dm/s scaling
  logic signed [31:0] dm_full;
  assign dm_full = 32'(b_y) * 32'(DM_GAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      airspeed_demand <= b_y;
      speed_demand_dm <= DM_W'(dm_full >>> 16);
    end
  end

endmodule

FILE: rtl/core/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks for the airspeed schedule core, bound to the top level.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bts_pkg::DATA_W-1:0] airspeed_demand,
  input logic signed [bts_pkg::DM_W-1:0]   speed_demand_dm
);
  import bts_pkg::*;

  logic signed [31:0] dm_exp;
  assign dm_exp = 32'(airspeed_demand) * 32'(DM_GAIN);

  // Nothing left over after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Input taken exactly when the output side can move
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // dm/s field agrees with the cm/s field
  a_dm_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_demand_dm == dm_exp[DM_W+15:16])
    else $error("speed_demand_dm inconsistent with airspeed_demand");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(airspeed_demand))
    else $error("stalled result changed");

endmodule

bind breakpoint_table_airspeed_schedule_core bts_checker u_bts_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .airspeed_demand(airspeed_demand),
  .speed_demand_dm(speed_demand_dm)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the breakpoint-table airspeed schedule core. A
// directed table (loads, mode and count extremes, end entries, flat spans,
// pitch extremes) is followed by random sorted tables with random content,
// unsorted noise loads and random evaluates. Each output beat is checked
// against a fixed expectation or an in-bench interpolation predictor. Both
// sides stall at random, with one long output hold-off to fill the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import bts_pkg::*;

  typedef enum int {ROW_LOAD, ROW_EVAL, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t op;
    int      idx, cond, cru, stl, vne, cam, pitch;
    int      mode, count, dflt;
    bit      has_exp;
    int      e_aspd, e_dm;
  } row_t;

  typedef struct {
    logic signed [DATA_W-1:0] aspd;
    logic signed [DM_W-1:0]   dm;
  } demand_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [IDX_W-1:0] entry_index = '0;
  logic signed [DATA_W-1:0] entry_condition = '0;
  logic [SPEED_W-1:0] entry_cruise = '0, entry_stall = '0, entry_vne = '0;
  logic signed [DATA_W-1:0] camber_input = '0, pitch_input = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] airspeed_demand;
  logic signed [DM_W-1:0] speed_demand_dm;

  breakpoint_table_airspeed_schedule_core DUT (.*);

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the table and registers
  int cond_tab[TABLE_DEPTH], cru_tab[TABLE_DEPTH], stl_tab[TABLE_DEPTH], vne_tab[TABLE_DEPTH];
  int sched_mode = 0, sched_count = 1, sched_dflt = 0;

  demand_t demand_q[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_req = 0, hold_done = 0;
  int hold_left = 0;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // normalised fixed-point linear interpolation
  function automatic int interp(input int x, input int x1, input int y1,
                                input int x2, input int y2);
    int span, off, gain;
    longint num, q, p;
    if (x2 <= x1 || y1 == y2) return y1;
    gain = 0;
    off  = x - x1;
    span = x2 - x1;
    while (span < HALF_SCALE) begin
      gain++;
      span = span << 1;
    end
    while (span > FULL_SCALE) begin
      gain--;
      span = span >> 1;
    end
    num = longint'(y2 - y1) * 65536;
    if (num > 0) begin
      while ((num >>> 16) > QUART_SCALE) begin
        gain++;
        num = num >>> 1;
      end
    end else begin
      while ((num >>> 16) < -QUART_SCALE) begin
        gain++;
        num = num >>> 1;
      end
    end
    q = sat16(num / span);
    p = q * off;
    if (gain >= 0) p = p <<< gain;
    else p = p >>> (-gain);
    return int'(sat16((p >>> 16) + y1));
  endfunction

  function automatic int speed_of(input int sel, input int i);
    if (sel == 0) return cru_tab[i];
    if (sel == 1) return stl_tab[i];
    return vne_tab[i];
  endfunction

  // sel: 0 cruise, 1 stall, 2 never-exceed
  function automatic int lookup_speed(input int cam, input int sel);
    int n;
    n = sched_count < 1 ? 1 : (sched_count > TABLE_DEPTH ? TABLE_DEPTH : sched_count);
    if (cam < cond_tab[0]) return speed_of(sel, 0);
    for (int i = 0; i + 1 < n; i++)
      if (cam >= cond_tab[i] && cam < cond_tab[i+1])
        return interp(cam, cond_tab[i], speed_of(sel, i), cond_tab[i+1], speed_of(sel, i+1));
    return speed_of(sel, n - 1);
  endfunction

  function automatic demand_t predict_demand(input int cam, input int pitch);
    demand_t d;
    int a, cr, pt;
    longint dm;
    if (sched_mode == MODE_CAMBER) a = lookup_speed(cam, 0);
    else if (sched_mode == MODE_CAMBER_PITCH) begin
      cr = lookup_speed(cam, 0);
      pt = lookup_speed(cam, pitch >= 0 ? 1 : 2);
      if (pitch >= 0) a = interp(pitch, 0, cr, FULL_SCALE, pt);
      else a = interp(pitch, -FULL_SCALE, pt, 0, cr);
    end else a = sched_dflt;
    dm = (longint'(a) * DM_GAIN) >>> 16;
    d.aspd = a[DATA_W-1:0];
    d.dm = dm[DM_W-1:0];
    return d;
  endfunction

  // register writes, only while idle
  task automatic set_regs(input int mode, input int count, input int dflt);
    cfg_we <= 1'b1; cfg_index <= CFG_MODE; cfg_data <= CFG_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_COUNT; cfg_data <= CFG_W'(count);
    @(posedge clk);
    cfg_index <= CFG_DEFAULT; cfg_data <= CFG_W'(dflt);
    @(posedge clk);
    cfg_we <= 1'b0;
    sched_mode = mode & 3;
    sched_count = count & 31;
    sched_dflt = dflt & 32'h7FFF;
  endtask

  task automatic drain_then_regs(input int mode, input int count, input int dflt);
    in_valid <= 1'b0;
    while (demand_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    set_regs(mode, count, dflt);
  endtask

  // offer one beat, wait for acceptance, update predictor
  task automatic send_beat(input row_t r);
    bit ok;
    demand_t d;
    func            <= (r.op == ROW_EVAL) ? FUNC_EVAL : FUNC_LOAD;
    entry_index     <= IDX_W'(r.idx);
    entry_condition <= DATA_W'(r.cond);
    entry_cruise    <= SPEED_W'(r.cru);
    entry_stall     <= SPEED_W'(r.stl);
    entry_vne       <= SPEED_W'(r.vne);
    camber_input    <= DATA_W'(r.cam);
    pitch_input     <= DATA_W'(r.pitch);
    in_valid        <= 1'b1;
    do begin
      @(negedge clk) ok = in_ready;
      @(posedge clk);
    end while (!ok);
    if (r.op == ROW_LOAD) begin
      cond_tab[r.idx] = r.cond;
      cru_tab[r.idx] = r.cru;
      stl_tab[r.idx] = r.stl;
      vne_tab[r.idx] = r.vne;
    end else if (r.has_exp) begin
      d.aspd = DATA_W'(r.e_aspd);
      d.dm = DM_W'(r.e_dm);
      demand_q.push_back(d);
    end else
      demand_q.push_back(predict_demand(r.cam, r.pitch));
    // sender gap
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  function automatic row_t mk_load(input int i, input int c, input int cr, input int s,
                                   input int v);
    row_t r;
    r = '{op: ROW_LOAD, default: 0};
    r.op = ROW_LOAD; r.idx = i; r.cond = c; r.cru = cr; r.stl = s; r.vne = v;
    r.cam = $urandom; r.pitch = $urandom;
    return r;
  endfunction

  function automatic row_t mk_eval(input int cam, input int pitch, input bit he,
                                   input int ea, input int ed);
    row_t r;
    r = '{op: ROW_EVAL, default: 0};
    r.op = ROW_EVAL; r.cam = cam; r.pitch = pitch;
    r.has_exp = he; r.e_aspd = ea; r.e_dm = ed;
    r.idx = $urandom; r.cond = $urandom; r.cru = $urandom; r.stl = $urandom;
    r.vne = $urandom;
    return r;
  endfunction

  function automatic row_t mk_cfg(input int m, input int n, input int d);
    row_t r;
    r = '{op: ROW_CFG, default: 0};
    r.op = ROW_CFG; r.mode = m; r.count = n; r.dflt = d;
    return r;
  endfunction

  function automatic int clamp16(input int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker: sample mid-cycle, beat taken at the next rising edge
  always @(negedge clk) begin
    demand_t e;
    if (!rst && out_valid && out_ready) begin
      if (demand_q.size() == 0) report("output beat with nothing expected");
      else begin
        e = demand_q.pop_front();
        if (airspeed_demand !== e.aspd)
          report($sformatf("airspeed_demand %0d, expected %0d", airspeed_demand, e.aspd));
        if (speed_demand_dm !== e.dm)
          report($sformatf("speed_demand_dm %0d, expected %0d", speed_demand_dm, e.dm));
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("breakpoint_table_airspeed_schedule_core verification failed");
    $finish;
  end

  initial begin
    row_t dir_rows[$];
    row_t r;
    int base, step, c, i, mode, count;

    // directed table: full sorted load, then end entries and extremes
    for (i = 0; i < TABLE_DEPTH; i++)
      dir_rows.push_back(mk_load(i, i == 15 ? 32767 : -32768 + i * 4369,
                                 i == 15 ? 32767 : i * 2000,
                                 i < 2 ? 500 : i * 1000, 32767 - i * 100));
    dir_rows.push_back(mk_eval(32767, 0, 1, 0, 0));           // single entry in use
    dir_rows.push_back(mk_eval(-32768, -16384, 1, 0, 0));
    dir_rows.push_back(mk_cfg(2, 1, 32767));
    dir_rows.push_back(mk_eval(100, 16384, 1, 32767, 3275));  // fixed cruise at max
    dir_rows.push_back(mk_cfg(3, 1, 0));
    dir_rows.push_back(mk_eval(-5, 5, 1, 0, 0));              // mode three as fixed
    dir_rows.push_back(mk_cfg(0, 16, 1));
    dir_rows.push_back(mk_eval(-32768, 0, 1, 0, 0));          // on first point
    dir_rows.push_back(mk_eval(32767, 0, 1, 32767, 3275));    // at last point
    dir_rows.push_back(mk_eval(0, 0, 0, 0, 0));
    dir_rows.push_back(mk_eval(-30000, 0, 0, 0, 0));          // flat stall span irrelevant
    dir_rows.push_back(mk_cfg(0, 31, 1));                     // count clipped to depth
    dir_rows.push_back(mk_eval(1234, 0, 0, 0, 0));
    dir_rows.push_back(mk_cfg(0, 0, 1));                      // count zero acts as one
    dir_rows.push_back(mk_eval(5, 0, 1, 0, 0));
    dir_rows.push_back(mk_cfg(1, 16, 1));
    dir_rows.push_back(mk_eval(-30000, 16384, 0, 0, 0));      // toward flat stall
    dir_rows.push_back(mk_eval(7000, 16384, 0, 0, 0));
    dir_rows.push_back(mk_eval(7000, -16384, 0, 0, 0));
    dir_rows.push_back(mk_eval(20000, -1, 0, 0, 0));
    dir_rows.push_back(mk_eval(32767, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 18;
    recv_idle = 81;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].op == ROW_CFG)
        drain_then_regs(dir_rows[k].mode, dir_rows[k].count, dir_rows[k].dflt);
      else send_beat(dir_rows[k]);
    end

    // random part: chunks of 50 beats, new settings between chunks
    for (int chunk = 0; chunk < 24; chunk++) begin
      if (chunk == 8) begin send_idle = 81; recv_idle = 18; end
      if (chunk == 16) begin send_idle = 0; recv_idle = 0; end
      mode = $urandom_range(3);
      if (mode == 3 && $urandom_range(1)) mode = 1;
      case ($urandom_range(9))
        0: count = $urandom_range(31);
        1: count = 16;
        2: count = 1;
        default: count = $urandom_range(2, 16);
      endcase
      drain_then_regs(mode, count, $urandom_range(9) == 0 ? 32767 * $urandom_range(1)
                                                          : $urandom_range(32767));
      if (chunk == 16) hold_req = 1;

      // fresh sorted table with random spans most of the time
      if ($urandom_range(2) != 0) begin
        case ($urandom_range(2))
          0: step = 8;
          1: step = 300;
          default: step = 4000;
        endcase
        base = -32768 + $urandom_range(0, 20000);
        for (i = 0; i < TABLE_DEPTH; i++) begin
          r = mk_load(i, clamp16(base), $urandom_range(32767), $urandom_range(32767),
                      $urandom_range(32767));
          if ($urandom_range(15) == 0) r.cru = $urandom_range(1) * 32767;
          send_beat(r);
          base = base + $urandom_range(1, step);
        end
      end

      for (int b = 0; b < 50; b++) begin
        if ($urandom_range(9) < 2) begin
          // noise: single entry overwritten, may break ordering
          send_beat(mk_load($urandom_range(15), $urandom_range(65535) - 32768,
                            $urandom_range(32767), $urandom_range(32767),
                            $urandom_range(32767)));
        end else begin
          i = $urandom_range(TABLE_DEPTH - 1);
          case ($urandom_range(4))
            0: c = $urandom_range(65535) - 32768;
            1: c = cond_tab[i];
            2: c = $urandom_range(1) ? 32767 : -32768;
            default: c = clamp16(cond_tab[i] + $urandom_range(0, 4000) - 50);
          endcase
          r = mk_eval(c, 0, 0, 0, 0);
          case ($urandom_range(7))
            0: r.pitch = 16384;
            1: r.pitch = -16384;
            2: r.pitch = $urandom_range(1) - 1;
            default: r.pitch = $urandom_range(32768) - 16384;
          endcase
          send_beat(r);
        end
      end
    end

    // wait for the pipeline to empty
    in_valid <= 1'b0;
    while (demand_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && demand_q.size() == 0)
      $display("breakpoint_table_airspeed_schedule_core verification clean");
    else
      $display("breakpoint_table_airspeed_schedule_core verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bts_pkg.sv
rtl/core/bts_ram.sv
rtl/core/bts_div.sv
rtl/core/bts_lerp.sv
rtl/core/breakpoint_table_airspeed_schedule_core.sv
rtl/core/bts_checker.sv
tb/tb.sv
